/* design/rwpc_pkg.sv */
// ----------------------------------------------------------------------------
// rwpc_pkg
// Shared types and constants of the ring wheel position controller.
// ----------------------------------------------------------------------------
package rwpc_pkg;

  typedef enum logic [1:0] {
    REG_STOP_RANGE = 2'd0,
    REG_MIN_SPEED  = 2'd1,
    REG_SPEED_GAIN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0] stop_range_half;
    logic [9:0] min_speed;
    logic [9:0] speed_gain;
  } cfg_t;

  typedef struct packed {
    logic [3:0] last_pocket;
    logic [4:0] position_est;
    logic       dir_neg;
    logic       strobe_armed;
    logic [2:0] entry_value;
  } sens_state_t;

  typedef struct packed {
    logic       entry_frozen;
    logic       halted;
    logic [7:0] drive_hi;
    logic [7:0] drive_lo;
    logic [4:0] last_error;
  } drive_state_t;

  localparam logic [3:0] STOP_RANGE_RST = 4'd1;
  localparam logic [9:0] MIN_SPEED_RST  = 10'd100;
  localparam logic [9:0] SPEED_GAIN_RST = 10'd160;

  localparam logic [7:0] BAND_KEEP_MASK = 8'hF0;
  localparam logic [7:0] MANUAL_MASK    = 8'h4F;
  localparam logic [7:0] HALT_KEEP_MASK = 8'h40;
  localparam logic [7:0] SPEED_HI_CLR   = 8'hFC;
  localparam logic [7:0] FWD_CLR        = 8'hF7;
  localparam logic [7:0] FWD_BIT        = 8'h04;
  localparam logic [7:0] REV_CLR        = 8'hFB;
  localparam logic [7:0] REV_BIT        = 8'h08;
  localparam logic [9:0] SPEED_MAX      = 10'd1023;

  localparam int IN_W  = 40;
  localparam int OUT_W = 40;

endpackage

/* design/ring_wheel_position_controller.sv */
// ----------------------------------------------------------------------------
// ring_wheel_position_controller
// Wheel encoder decode and position/manual motor drive, one tick per transfer.
// ----------------------------------------------------------------------------
// One input transfer is one control tick and yields exactly one result
// transfer. The tick is captured in an input register, all decode and drive
// logic (including the 5x10 speed multiply) is combinational from that
// register and the held wheel state, and the result lands in an output
// register. A new tick is taken every cycle unless the output stalls; its
// result then passes to the output register. Back-pressure on the output holds
// the input register, then in_tready. The configuration channel is always ready
// and should be written only while no tick is in flight.
module ring_wheel_position_controller #(
  parameter int RING_POCKETS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // enable, ball_in_stop, ball_in_hold, position_mode, target_half[4:0],
  // manual_control[7:0], manual_speed[7:0], position_sensors[4:0],
  // entry_sensors[3:0], direction_sensors[1:0], zero fill
  input  logic [rwpc_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // drive_control[7:0], drive_speed_low[7:0], pocket_code[3:0],
  // position_half[4:0], pocket_entered[2:0], position_error[4:0],
  // wheel_stopped, zero fill
  output logic [rwpc_pkg::OUT_W-1:0] out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [9:0]                 cfg_data
);

  logic                      in_valid_r, in_valid_nxt;
  logic [rwpc_pkg::IN_W-1:0] in_data_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [rwpc_pkg::OUT_W-1:0] out_data_r, out_data_nxt;
  logic                      advance;

  rwpc_pkg::cfg_t         cfg_r;
  rwpc_pkg::sens_state_t  sens_r, sens_nxt;
  rwpc_pkg::drive_state_t drv_r, drv_nxt;

  assign advance    = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready  = ~in_valid_r | advance;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  rwpc_sensor #(.RING_POCKETS(RING_POCKETS)) u_sensor (
    .cur               (sens_r),
    .entry_frozen      (drv_r.entry_frozen),
    .position_sensors  (in_data_r[29:25]),
    .entry_sensors     (in_data_r[33:30]),
    .direction_sensors (in_data_r[35:34]),
    .nxt               (sens_nxt)
  );

  rwpc_drive #(.RING_POCKETS(RING_POCKETS)) u_drive (
    .cur            (drv_r),
    .cfg            (cfg_r),
    .enable         (in_data_r[0]),
    .ball_in_stop   (in_data_r[1]),
    .ball_in_hold   (in_data_r[2]),
    .position_mode  (in_data_r[3]),
    .target_half    (in_data_r[8:4]),
    .manual_control (in_data_r[16:9]),
    .manual_speed   (in_data_r[24:17]),
    .entry_value    (sens_nxt.entry_value),
    .position_est   (sens_nxt.position_est),
    .nxt            (drv_nxt)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    out_data_nxt = {6'd0, drv_nxt.halted, drv_nxt.last_error, sens_nxt.entry_value,
                    sens_nxt.position_est, sens_nxt.last_pocket,
                    drv_nxt.drive_lo, drv_nxt.drive_hi};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{stop_range_half: rwpc_pkg::STOP_RANGE_RST,
                       min_speed:       rwpc_pkg::MIN_SPEED_RST,
                       speed_gain:      rwpc_pkg::SPEED_GAIN_RST};
      sens_r      <= '{last_pocket: 4'd0, position_est: 5'd0, dir_neg: 1'b0,
                       strobe_armed: 1'b1, entry_value: 3'd0};
      drv_r       <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        sens_r <= sens_nxt;
        drv_r  <= drv_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          rwpc_pkg::REG_STOP_RANGE: cfg_r.stop_range_half <= cfg_data[3:0];
          rwpc_pkg::REG_MIN_SPEED:  cfg_r.min_speed       <= cfg_data;
          rwpc_pkg::REG_SPEED_GAIN: cfg_r.speed_gain      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* design/rwpc_sensor.sv */
// ----------------------------------------------------------------------------
// rwpc_sensor
// Encoder decode, position estimate, direction tracking and entry detect.
// ----------------------------------------------------------------------------
module rwpc_sensor #(
  parameter int RING_POCKETS = 12
) (
  input  rwpc_pkg::sens_state_t cur,
  input  logic                  entry_frozen,
  input  logic [4:0]            position_sensors,
  input  logic [3:0]            entry_sensors,
  input  logic [1:0]            direction_sensors,
  output rwpc_pkg::sens_state_t nxt
);

  localparam logic signed [6:0] RING_M1 = 7'(RING_POCKETS - 1);
  localparam logic signed [6:0] RING2   = 7'(2 * RING_POCKETS);
  localparam logic [4:0]        WRAP_LO = 5'(2 * RING_POCKETS - 1);

  logic [3:0]        code;
  logic signed [6:0] diff;
  logic              step_neg;
  logic              est_neg;
  logic signed [6:0] est;
  logic [4:0]        est_wrap;

  always_comb begin
    code = position_sensors[4:1];
    diff = $signed({3'b000, code}) - $signed({3'b000, cur.last_pocket});

    priority if (diff == 7'sd0) begin
      step_neg = cur.dir_neg;
    end else if (diff == RING_M1) begin
      step_neg = 1'b1;
    end else if (diff == -RING_M1) begin
      step_neg = 1'b0;
    end else begin
      step_neg = diff < 7'sd0;
    end

    priority if (direction_sensors[0]) begin
      est_neg = 1'b0;
    end else if (direction_sensors[1]) begin
      est_neg = 1'b1;
    end else begin
      est_neg = cur.dir_neg;
    end

    est = $signed({2'b00, cur.last_pocket, 1'b0}) + (est_neg ? -7'sd1 : 7'sd1);
    priority if (est < 7'sd0) begin
      est_wrap = WRAP_LO;
    end else if (est > RING2) begin
      est_wrap = 5'd1;
    end else begin
      est_wrap = est[4:0];
    end

    nxt = cur;

    if (!entry_frozen) begin
      priority if (entry_sensors[0]) nxt.entry_value = 3'd1;
      else if (entry_sensors[1]) nxt.entry_value = 3'd2;
      else if (entry_sensors[2]) nxt.entry_value = 3'd3;
      else if (entry_sensors[3]) nxt.entry_value = 3'd4;
      else nxt.entry_value = 3'd0;
    end

    if (position_sensors[0]) begin
      if (cur.strobe_armed) begin
        if (code != 4'd0) begin
          nxt.dir_neg      = step_neg;
          nxt.last_pocket  = code;
          nxt.position_est = {code, 1'b0};
        end else begin
          nxt.position_est = est_wrap;
        end
      end
      nxt.strobe_armed = 1'b0;
    end else begin
      nxt.strobe_armed = 1'b1;
    end
  end

endmodule

/* design/rwpc_drive.sv */
// ----------------------------------------------------------------------------
// rwpc_drive
// Motor drive: ring error, dead band, proportional speed, halt and manual.
// ----------------------------------------------------------------------------
module rwpc_drive #(
  parameter int RING_POCKETS = 12
) (
  input  rwpc_pkg::drive_state_t cur,
  input  rwpc_pkg::cfg_t         cfg,
  input  logic                   enable,
  input  logic                   ball_in_stop,
  input  logic                   ball_in_hold,
  input  logic                   position_mode,
  input  logic [4:0]             target_half,
  input  logic [7:0]             manual_control,
  input  logic [7:0]             manual_speed,
  input  logic [2:0]             entry_value,
  input  logic [4:0]             position_est,
  output rwpc_pkg::drive_state_t nxt
);

  localparam logic signed [6:0] RING_S  = 7'(RING_POCKETS);
  localparam logic signed [6:0] RING2_S = 7'(2 * RING_POCKETS);

  logic signed [6:0] err_raw;
  logic signed [6:0] err;
  logic signed [6:0] err_neg;
  logic [4:0]        err_rep;
  logic [4:0]        mag;
  logic [14:0]       prod;
  logic [10:0]       spd_sum;
  logic [9:0]        speed;
  logic              in_band;
  logic [7:0]        dir_hi;
  logic [7:0]        pos_hi;
  logic [7:0]        pos_lo;
  logic              halted_n;

  always_comb begin
    err_raw = $signed({2'b00, target_half}) - $signed({2'b00, position_est});
    priority if (err_raw > RING_S) begin
      err = err_raw - RING2_S;
    end else if (err_raw < -RING_S) begin
      err = err_raw + RING2_S;
    end else begin
      err = err_raw;
    end
    err_neg = -err;

    priority if (err > 7'sd15) begin
      err_rep = 5'b01111;
    end else if (err < -7'sd16) begin
      err_rep = 5'b10000;
    end else begin
      err_rep = err[4:0];
    end

    mag     = (err < 7'sd0) ? err_neg[4:0] : err[4:0];
    prod    = 15'(mag) * 15'(cfg.speed_gain);
    spd_sum = 11'(cfg.min_speed) + 11'(prod[14:5]);
    speed   = (spd_sum > {1'b0, rwpc_pkg::SPEED_MAX}) ? rwpc_pkg::SPEED_MAX : spd_sum[9:0];
    in_band = mag <= {1'b0, cfg.stop_range_half};

    dir_hi = (err > 7'sd0) ? ((cur.drive_hi & rwpc_pkg::FWD_CLR) | rwpc_pkg::FWD_BIT)
                           : ((cur.drive_hi & rwpc_pkg::REV_CLR) | rwpc_pkg::REV_BIT);
    if (in_band) begin
      pos_hi = cur.drive_hi & rwpc_pkg::BAND_KEEP_MASK;
      pos_lo = 8'd0;
    end else begin
      pos_hi = (dir_hi & rwpc_pkg::SPEED_HI_CLR) | {6'b000000, speed[9:8]};
      pos_lo = speed[7:0];
    end

    nxt      = cur;
    halted_n = cur.halted;
    if (enable) begin
      if (ball_in_hold) begin
        if (entry_value != 3'd0) nxt.entry_frozen = 1'b1;
      end else begin
        nxt.entry_frozen = 1'b0;
      end
      if (ball_in_stop) begin
        halted_n = cur.halted | (entry_value != 3'd0);
      end else begin
        halted_n = 1'b0;
      end
      nxt.halted = halted_n;
      if (ball_in_stop && halted_n) begin
        nxt.drive_hi = cur.drive_hi & rwpc_pkg::HALT_KEEP_MASK;
        nxt.drive_lo = 8'd0;
      end else if (position_mode) begin
        nxt.last_error = err_rep;
        nxt.drive_hi   = pos_hi;
        nxt.drive_lo   = pos_lo;
      end else begin
        nxt.drive_hi = manual_control & rwpc_pkg::MANUAL_MASK;
        nxt.drive_lo = manual_speed;
      end
    end else begin
      nxt.drive_hi = 8'd0;
      nxt.drive_lo = 8'd0;
      nxt.halted   = 1'b0;
    end
  end

endmodule
